@@ src/ncs_pkg.sv @@
`timescale 1ns / 1ps

package ncs_pkg;

  // Operation codes carried by an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Fixed field widths.
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int DIST_W = 34;

  // Largest distance that the result field can hold.
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Configuration register.
  localparam logic             REG_ENTRIES_IN_USE = 1'b0;
  localparam logic [CNT_W-1:0] ENTRIES_IN_USE_RST = 9'd256;

  // Search sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ncs_state_e;

  // Tag that travels alongside each codebook read through the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } ncs_tag_t;

endpackage

@@ src/nearest_codeword_search.sv @@
`timescale 1ns / 1ps

// Load item: written to the codebook memory at the same edge at which it is accepted.
// Query item: the sequencer reads the first N entries in order, N being the searched count;
// the codebook memory gives one entry per cycle, and each passes the memory read register
// and the three distance stages. The next item is accepted once the result register is loaded
// after the last entry, later if the previous result has not yet been taken. Loads and queries
// are not accepted while a search runs; a finished result waits in its own register. Reset
// clears the control state and sets the count to 256; the codebook is not cleared.

module nearest_codeword_search #(
  parameter int ENTRIES         = 256,
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               op_i,
  input  logic [ncs_pkg::IDX_W-1:0]          entry_index_i,
  input  logic [COMPONENT_WIDTH-1:0]         comp_a_i,
  input  logic [COMPONENT_WIDTH-1:0]         comp_b_i,
  input  logic [COMPONENT_WIDTH-1:0]         comp_c_i,

  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ncs_pkg::IDX_W-1:0]          best_index_o,
  output logic [ncs_pkg::DIST_W-1:0]         best_distance_sq_o,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int AW = $clog2(ENTRIES);

  ncs_pkg::ncs_state_e state_q, state_d;

  logic [ncs_pkg::CNT_W-1:0] cfg_q;
  logic [ncs_pkg::CNT_W-1:0] eff_cnt;
  logic [ncs_pkg::IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [ncs_pkg::IDX_W-1:0] last_idx_q, last_idx_d;
  logic [CW-1:0]             q_a_q, q_b_q, q_c_q;
  ncs_pkg::ncs_tag_t         tag_rd_q, tag_rd_d, tag_dist;
  logic [ncs_pkg::DIST_W-1:0] dist_val;
  logic [ncs_pkg::IDX_W-1:0] best_idx_q;
  logic [ncs_pkg::DIST_W-1:0] best_dist_q;
  logic                      out_valid_q;
  logic [ncs_pkg::IDX_W-1:0] out_idx_q;
  logic [ncs_pkg::DIST_W-1:0] out_dist_q;

  logic                      in_fire, load_fire, query_fire, slot_ok, out_load;
  logic [3*CW-1:0]           rdata;

  // Configuration port: one register, decoded on the word address only.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ncs_pkg::ENTRIES_IN_USE_RST;
    end else if (psel && penable && pwrite && (paddr[2] == ncs_pkg::REG_ENTRIES_IN_USE)) begin
      cfg_q <= pwdata[ncs_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ncs_pkg::REG_ENTRIES_IN_USE) begin
      prdata = 32'(cfg_q);
    end
  end

  // Effective search count: zero means one, and it never exceeds the codebook depth.
  always_comb begin
    if (cfg_q == '0) begin
      eff_cnt = ncs_pkg::CNT_W'(1);
    end else if (32'(cfg_q) > ENTRIES) begin
      eff_cnt = ncs_pkg::CNT_W'(ENTRIES);
    end else begin
      eff_cnt = cfg_q;
    end
  end

  // Input handshake.
  assign in_ready_o = (state_q == ncs_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_ok    = (32'(entry_index_i) < ENTRIES);
  assign load_fire  = in_fire && (op_i == ncs_pkg::OP_LOAD) && slot_ok;
  assign query_fire = in_fire && (op_i == ncs_pkg::OP_QUERY);

  // Codebook memory, components packed with the first in the low bits.
  ncs_ram #(
    .WIDTH (3 * CW),
    .DEPTH (ENTRIES)
  ) u_codebook (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({comp_c_i, comp_b_i, comp_a_i}),
    .raddr_i (AW'(rd_idx_q)),
    .rdata_o (rdata)
  );

  // Distance pipeline.
  ncs_dist #(
    .CW (CW)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .query_a_i (q_a_q),
    .query_b_i (q_b_q),
    .query_c_i (q_c_q),
    .entry_i   (rdata),
    .tag_i     (tag_rd_q),
    .dist_o    (dist_val),
    .tag_o     (tag_dist)
  );

  // Sequencer: next state and read issue.
  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    last_idx_d = last_idx_q;
    tag_rd_d   = '0;
    out_load   = 1'b0;
    case (state_q)
      ncs_pkg::ST_IDLE: begin
        if (query_fire) begin
          rd_idx_d   = '0;
          last_idx_d = ncs_pkg::IDX_W'(eff_cnt - ncs_pkg::CNT_W'(1));
          state_d    = ncs_pkg::ST_SCAN;
        end
      end
      ncs_pkg::ST_SCAN: begin
        tag_rd_d.valid = 1'b1;
        tag_rd_d.last  = (rd_idx_q == last_idx_q);
        tag_rd_d.idx   = rd_idx_q;
        rd_idx_d       = rd_idx_q + ncs_pkg::IDX_W'(1);
        if (rd_idx_q == last_idx_q) begin
          state_d = ncs_pkg::ST_DRAIN;
        end
      end
      ncs_pkg::ST_DRAIN: begin
        if (tag_dist.valid && tag_dist.last) begin
          state_d = ncs_pkg::ST_FINISH;
        end
      end
      ncs_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ncs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ncs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ncs_pkg::ST_IDLE;
      rd_idx_q   <= '0;
      last_idx_q <= '0;
      tag_rd_q   <= '0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      last_idx_q <= last_idx_d;
      tag_rd_q   <= tag_rd_d;
    end
  end

  // Query vector is held for the whole search.
  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      q_a_q <= comp_a_i;
      q_b_q <= comp_b_i;
      q_c_q <= comp_c_i;
    end
  end

  // Running minimum; entry zero always seeds it and ties keep the lower index.
  always_ff @(posedge clk_i) begin
    if (tag_dist.valid && ((tag_dist.idx == '0) || (dist_val < best_dist_q))) begin
      best_idx_q  <= tag_dist.idx;
      best_dist_q <= dist_val;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= best_idx_q;
      out_dist_q <= best_dist_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign best_index_o       = out_idx_q;
  assign best_distance_sq_o = out_dist_q;

endmodule

@@ src/ncs_ram.sv @@
`timescale 1ns / 1ps

module ncs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/ncs_dist.sv @@
`timescale 1ns / 1ps

module ncs_dist #(
  parameter int CW = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [CW-1:0]                query_a_i,
  input  logic [CW-1:0]                query_b_i,
  input  logic [CW-1:0]                query_c_i,
  input  logic [3*CW-1:0]              entry_i,
  input  ncs_pkg::ncs_tag_t            tag_i,
  output logic [ncs_pkg::DIST_W-1:0]   dist_o,
  output ncs_pkg::ncs_tag_t            tag_o
);

  localparam int AW_ = CW + 1;
  localparam int PW  = 2 * AW_;
  localparam int SW  = PW + 2;
  localparam int XW  = (SW > ncs_pkg::DIST_W) ? SW : ncs_pkg::DIST_W;

  logic signed [AW_-1:0] diff_a, diff_b, diff_c;
  logic [AW_-1:0] abs_a_q, abs_b_q, abs_c_q;
  logic [PW-1:0]  sq_a_q, sq_b_q, sq_c_q;
  logic [SW-1:0]  sum;
  logic [XW-1:0]  sum_x;
  logic [ncs_pkg::DIST_W-1:0] dist_q;
  ncs_pkg::ncs_tag_t tag1_q, tag2_q, tag3_q;

  // Component differences, sign extended by one bit so they cannot overflow.
  always_comb begin
    diff_a = $signed({entry_i[CW-1], entry_i[CW-1:0]})
           - $signed({query_a_i[CW-1], query_a_i});
    diff_b = $signed({entry_i[2*CW-1], entry_i[2*CW-1:CW]})
           - $signed({query_b_i[CW-1], query_b_i});
    diff_c = $signed({entry_i[3*CW-1], entry_i[3*CW-1:2*CW]})
           - $signed({query_c_i[CW-1], query_c_i});
  end

  // Stage one: magnitudes of the differences.
  always_ff @(posedge clk_i) begin
    abs_a_q <= diff_a[AW_-1] ? AW_'(-diff_a) : AW_'(diff_a);
    abs_b_q <= diff_b[AW_-1] ? AW_'(-diff_b) : AW_'(diff_b);
    abs_c_q <= diff_c[AW_-1] ? AW_'(-diff_c) : AW_'(diff_c);
  end

  // Stage two: one multiplier per component.
  always_ff @(posedge clk_i) begin
    sq_a_q <= PW'(abs_a_q) * PW'(abs_a_q);
    sq_b_q <= PW'(abs_b_q) * PW'(abs_b_q);
    sq_c_q <= PW'(abs_c_q) * PW'(abs_c_q);
  end

  // Stage three: sum of squares, saturated to the result width.
  always_comb begin
    sum   = SW'(sq_a_q) + SW'(sq_b_q) + SW'(sq_c_q);
    sum_x = XW'(sum);
  end

  always_ff @(posedge clk_i) begin
    if (sum_x > XW'(ncs_pkg::DIST_MAX)) begin
      dist_q <= ncs_pkg::DIST_MAX;
    end else begin
      dist_q <= ncs_pkg::DIST_W'(sum_x);
    end
  end

  // The tag follows the data through all three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  assign dist_o = dist_q;
  assign tag_o  = tag3_q;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int ENTRIES         = 256;
  localparam int COMPONENT_WIDTH = 16;
  // Longest search plus pipeline, with margin, before the block counts as idle.
  localparam int SETTLE_CYCLES   = ENTRIES + 14;
  localparam int PHASE_ITEMS     = 110;

  typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;

  typedef struct {
    logic                      op;
    logic [ncs_pkg::IDX_W-1:0] slot;
    comp_t                     a;
    comp_t                     b;
    comp_t                     c;
  } search_item_t;

  typedef struct {
    logic [ncs_pkg::IDX_W-1:0]  index;
    logic [ncs_pkg::DIST_W-1:0] dist_sq;
  } nearest_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       op_i = ncs_pkg::OP_LOAD;
  logic [ncs_pkg::IDX_W-1:0]  entry_index_i = '0;
  logic [COMPONENT_WIDTH-1:0] comp_a_i = '0;
  logic [COMPONENT_WIDTH-1:0] comp_b_i = '0;
  logic [COMPONENT_WIDTH-1:0] comp_c_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [ncs_pkg::IDX_W-1:0]  best_index_o;
  logic [ncs_pkg::DIST_W-1:0] best_distance_sq_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [2:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  // Predictor state: the codebook as the block should hold it, and the count.
  comp_t                     book_a [ENTRIES];
  comp_t                     book_b [ENTRIES];
  comp_t                     book_c [ENTRIES];
  logic [ncs_pkg::CNT_W-1:0] entries_cfg = ncs_pkg::ENTRIES_IN_USE_RST;

  search_item_t queued_items[$];
  nearest_t     pending_nearest[$];

  int errors    = 0;
  int n_loads   = 0;
  int n_queries = 0;
  int n_results = 0;
  int n_configs = 0;

  bit in_gaps_on  = 1'b1;
  bit out_stalls_on = 1'b1;

  nearest_codeword_search #(
    .ENTRIES         (ENTRIES),
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .entry_index_i      (entry_index_i),
    .comp_a_i           (comp_a_i),
    .comp_b_i           (comp_b_i),
    .comp_c_i           (comp_c_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .best_index_o       (best_index_o),
    .best_distance_sq_o (best_distance_sq_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A count of zero searches entry 0 only; anything above the codebook size saturates.
  function automatic int effective_count();
    if (entries_cfg == 0) begin
      return 1;
    end
    if (entries_cfg > ENTRIES) begin
      return ENTRIES;
    end
    return int'(entries_cfg);
  endfunction

  function automatic logic [ncs_pkg::DIST_W-1:0] squared_gap(int slot, comp_t qa, comp_t qb,
                                                             comp_t qc);
    longint da;
    longint db;
    longint dc;
    longint sum;
    da  = longint'(book_a[slot]) - longint'(qa);
    db  = longint'(book_b[slot]) - longint'(qb);
    dc  = longint'(book_c[slot]) - longint'(qc);
    sum = da * da + db * db + dc * dc;
    if (sum > longint'(ncs_pkg::DIST_MAX)) begin
      sum = longint'(ncs_pkg::DIST_MAX);
    end
    return ncs_pkg::DIST_W'(sum);
  endfunction

  // Apply one accepted item: a load updates the codebook, a query yields the nearest entry.
  function automatic void search_nearest(search_item_t item);
    nearest_t                   best;
    logic [ncs_pkg::DIST_W-1:0] d;
    int                         count;
    if (item.op == ncs_pkg::OP_LOAD) begin
      book_a[item.slot] = item.a;
      book_b[item.slot] = item.b;
      book_c[item.slot] = item.c;
      n_loads++;
    end else begin
      count        = effective_count();
      best.index   = '0;
      best.dist_sq = squared_gap(0, item.a, item.b, item.c);
      for (int i = 1; i < count; i++) begin
        d = squared_gap(i, item.a, item.b, item.c);
        // Strictly smaller only, so the lowest index keeps a tie.
        if (d < best.dist_sq) begin
          best.dist_sq = d;
          best.index   = ncs_pkg::IDX_W'(i);
        end
      end
      pending_nearest = {pending_nearest, best};
      n_queries++;
    end
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 7))
      0: return comp_t'(-32768);
      1: return comp_t'(32767);
      2: return comp_t'($urandom_range(0, 16)) - comp_t'(8);
      default: return comp_t'($urandom);
    endcase
  endfunction

  task automatic push_item(logic op, int slot, comp_t a, comp_t b, comp_t c);
    search_item_t item;
    item.op   = op;
    item.slot = ncs_pkg::IDX_W'(slot);
    item.a    = a;
    item.b    = b;
    item.c    = c;
    queued_items = {queued_items, item};
  endtask

  // Mostly queries that land on or near stored entries, so ties and close calls occur;
  // loads partly copy existing entries to create equal distances.
  task automatic add_random_items(int n);
    int   count;
    int   src;
    int   slot;
    logic op;
    comp_t a, b, c;
    count = effective_count();
    for (int k = 0; k < n; k++) begin
      op  = ($urandom_range(0, 9) < 6) ? ncs_pkg::OP_QUERY : ncs_pkg::OP_LOAD;
      src = $urandom_range(0, count - 1);
      a   = rand_comp();
      b   = rand_comp();
      c   = rand_comp();
      if (op == ncs_pkg::OP_QUERY) begin
        case ($urandom_range(0, 9))
          4, 5, 6: begin
            a = book_a[src] + comp_t'($urandom_range(0, 6)) - comp_t'(3);
            b = book_b[src] + comp_t'($urandom_range(0, 6)) - comp_t'(3);
            c = book_c[src] + comp_t'($urandom_range(0, 6)) - comp_t'(3);
          end
          7, 8, 9: begin
            a = book_a[src];
            b = book_b[src];
            c = book_c[src];
          end
          default: ;
        endcase
        slot = $urandom_range(0, ENTRIES - 1);
      end else begin
        slot = $urandom_range(0, 1) ? $urandom_range(0, count - 1)
                                    : $urandom_range(0, ENTRIES - 1);
        if ($urandom_range(0, 3) == 0) begin
          a = book_a[src];
          b = book_b[src];
          c = book_c[src];
        end
      end
      push_item(op, slot, a, b, c);
    end
  endtask

  // Wait until every item has gone in and every result has come out, then let
  // a possible search in flight finish.
  task automatic wait_idle();
    while (queued_items.size() != 0 || in_valid_i || pending_nearest.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the count over the register port, read it back and update the predictor.
  task automatic set_entries_in_use(logic [ncs_pkg::CNT_W-1:0] value);
    logic [31:0] readback;
    wait_idle();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ncs_pkg::REG_ENTRIES_IN_USE, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel     <= 1'b0;
    penable  <= 1'b0;
    if (readback !== 32'(value)) begin
      $error("entries_in_use: expected %0d, got %0d", value, readback);
      errors++;
    end
    entries_cfg = value;
    n_configs++;
    @(negedge clk_i);
  endtask

  // Input side: one item at a time from the queue, with a random gap after each while gaps are on.
  search_item_t in_cur;
  bit           in_next;
  int           in_gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_next = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        search_nearest(in_cur);
        in_next     = 1'b0;
        in_gap_left = in_gaps_on ? $urandom_range(0, 9) : 0;
      end
      if (!in_next) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
        end else if (queued_items.size() != 0) begin
          in_cur        = queued_items.pop_front();
          op_i          <= in_cur.op;
          entry_index_i <= in_cur.slot;
          comp_a_i      <= in_cur.a;
          comp_b_i      <= in_cur.b;
          comp_c_i      <= in_cur.c;
          in_next       = 1'b1;
        end
      end
      in_valid_i <= in_next;
    end
  end

  // Result side: check each accepted result against the oldest expectation.
  nearest_t want;
  int       out_stall_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (pending_nearest.size() == 0) begin
          $error("unexpected result: best_index %0d, best_distance_sq %0d",
                 best_index_o, best_distance_sq_o);
          errors++;
        end else begin
          want = pending_nearest.pop_front();
          if (best_index_o !== want.index) begin
            $error("best_index: expected %0d, got %0d", want.index, best_index_o);
            errors++;
          end
          if (best_distance_sq_o !== want.dist_sq) begin
            $error("best_distance_sq: expected %0d, got %0d", want.dist_sq,
                   best_distance_sq_o);
            errors++;
          end
        end
        out_stall_left = out_stalls_on ? $urandom_range(0, 9) : 0;
      end else if (out_stall_left > 0) begin
        out_stall_left--;
      end
      out_ready_i <= (out_stall_left == 0);
    end
  end

  // Stimulus and configuration phases.
  logic [ncs_pkg::CNT_W-1:0] phase_counts [8];

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Single entry searched: extremes of every component.
    set_entries_in_use(ncs_pkg::CNT_W'(1));
    push_item(ncs_pkg::OP_LOAD, 0, comp_t'(-32768), comp_t'(-32768), comp_t'(-32768));
    push_item(ncs_pkg::OP_QUERY, 0, comp_t'(32767), comp_t'(32767), comp_t'(32767));
    push_item(ncs_pkg::OP_QUERY, 255, comp_t'(-32768), comp_t'(-32768), comp_t'(-32768));
    push_item(ncs_pkg::OP_LOAD, 1, comp_t'(0), comp_t'(0), comp_t'(0));
    push_item(ncs_pkg::OP_QUERY, 0, comp_t'(0), comp_t'(0), comp_t'(0));
    push_item(ncs_pkg::OP_LOAD, 255, comp_t'(32767), comp_t'(-1), comp_t'(0));

    // A count of zero behaves as one.
    set_entries_in_use(ncs_pkg::CNT_W'(0));
    push_item(ncs_pkg::OP_QUERY, 0, comp_t'(32767), comp_t'(-1), comp_t'(0));
    push_item(ncs_pkg::OP_QUERY, 0, comp_t'(-32767), comp_t'(-32768), comp_t'(-32766));

    // Two entries: an exact tie goes to the lower index, then a distance of one.
    set_entries_in_use(ncs_pkg::CNT_W'(2));
    push_item(ncs_pkg::OP_LOAD, 1, comp_t'(-32768), comp_t'(-32768), comp_t'(-32768));
    push_item(ncs_pkg::OP_QUERY, 0, comp_t'(100), comp_t'(-200), comp_t'(300));
    push_item(ncs_pkg::OP_LOAD, 1, comp_t'(32767), comp_t'(32767), comp_t'(32767));
    push_item(ncs_pkg::OP_QUERY, 0, comp_t'(32767), comp_t'(32767), comp_t'(32766));
    push_item(ncs_pkg::OP_QUERY, 0, comp_t'(-32768), comp_t'(-32768), comp_t'(-32767));

    // Fill the whole codebook so that any count reads only written entries.
    wait_idle();
    for (int i = 0; i < ENTRIES; i++) begin
      push_item(ncs_pkg::OP_LOAD, i, rand_comp(), rand_comp(), rand_comp());
    end

    phase_counts[0] = ncs_pkg::CNT_W'(ENTRIES);
    phase_counts[1] = ncs_pkg::CNT_W'(511);
    phase_counts[2] = ncs_pkg::CNT_W'(1);
    phase_counts[3] = ncs_pkg::CNT_W'(0);
    for (int p = 4; p < 8; p++) begin
      phase_counts[p] = ncs_pkg::CNT_W'($urandom_range(2, ENTRIES - 1));
    end

    for (int p = 0; p < 8; p++) begin
      set_entries_in_use(phase_counts[p]);
      // The first phase runs without any idling; later ones mostly with it.
      in_gaps_on    = (p != 0) && ($urandom_range(0, 3) != 0);
      out_stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
      add_random_items(PHASE_ITEMS);
    end

    wait_idle();
    $display("Ran %0d loads and %0d queries under %0d count settings (extremes 0, 1, 256, 511).",
             n_loads, n_queries, n_configs);
    $display("Checked %0d nearest-entry results.", n_results);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d results still outstanding.", pending_nearest.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
